// ----- design/lr_pkg.sv -----
// Shared types and constants for the line rasteriser.
// No dependencies; every other file imports this package.
`default_nettype none

package lr_pkg;

	localparam int VP_BITS    = 13;   // viewport width/height registers
	localparam int ADDR_BITS  = 24;   // frame-buffer word address
	localparam int COLOR_BITS = 32;

	localparam logic [VP_BITS-1:0] VP_WIDTH_RESET  = 13'd640;
	localparam logic [VP_BITS-1:0] VP_HEIGHT_RESET = 13'd480;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_VP_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_VP_HEIGHT = 1'b1;

	// input item actions
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	typedef struct packed {
		logic valid_res;   // a pixel was emitted
		logic last;        // pixel is the line endpoint
	} lr_flags_t;

endpackage

`default_nettype wire

// ----- design/lr_step.sv -----
// Bresenham state and first pipeline stage: line set-up, one error-term
// update per step item, emitted pixel registered in stage 1. Uses lr_pkg.
`default_nettype none

module lr_step import lr_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         action,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic [COLOR_BITS-1:0]        line_color,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output lr_flags_t                         flags_s1,
	output logic signed [COORD_BITS-1:0]      pixel_x_s1,
	output logic signed [COORD_BITS-1:0]      pixel_y_s1,
	output logic [COLOR_BITS-1:0]             color_s1
);

	localparam int DW = COORD_BITS + 1;   // |delta|
	localparam int EW = COORD_BITS + 3;   // error term
	localparam int E2W = EW + 1;          // doubled error term

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [DW-1:0]                abs_dx_q, abs_dy_q;
	logic                         x_neg_q, y_neg_q;
	logic signed [EW-1:0]         err_q;
	logic [COLOR_BITS-1:0]        color_q;
	logic                         active_q;
	logic                         valid_s1;

	logic                         take, is_start, emit;
	logic signed [DW-1:0]         dx_raw, dy_raw;
	logic [DW-1:0]                dx_abs, dy_abs;
	logic                         x_neg, y_neg;
	logic signed [EW-1:0]         err_start, err_step, dx_w, dy_w;
	logic signed [E2W-1:0]        e2, dx_e, dy_e;
	logic                         go_x, go_y;
	logic signed [COORD_BITS-1:0] x_step, y_step, px, py, tx, ty;
	logic                         at_end;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign take      = in_valid && in_ready;
	assign is_start  = (action == ACT_START);
	assign emit      = is_start || active_q;

	// line set-up
	always_comb begin
		dx_raw    = DW'(end_x) - DW'(start_x);
		dy_raw    = DW'(end_y) - DW'(start_y);
		dx_abs    = dx_raw[DW-1] ? DW'(-dx_raw) : DW'(dx_raw);
		dy_abs    = dy_raw[DW-1] ? DW'(-dy_raw) : DW'(dy_raw);
		x_neg     = dx_raw[DW-1] || (dx_raw == '0);
		y_neg     = dy_raw[DW-1] || (dy_raw == '0);
		err_start = $signed(EW'(dx_abs)) - $signed(EW'(dy_abs));
	end

	// one Bresenham step from the held state
	always_comb begin
		e2       = {err_q, 1'b0};
		dx_e     = $signed(E2W'(abs_dx_q));
		dy_e     = $signed(E2W'(abs_dy_q));
		dx_w     = $signed(EW'(abs_dx_q));
		dy_w     = $signed(EW'(abs_dy_q));
		go_x     = e2 > -dy_e;
		go_y     = e2 < dx_e;
		err_step = err_q - (go_x ? dy_w : EW'(0)) + (go_y ? dx_w : EW'(0));
		x_step   = go_x ? (x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1) : cur_x_q;
		y_step   = go_y ? (y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1) : cur_y_q;
	end

	always_comb begin
		px     = is_start ? start_x : x_step;
		py     = is_start ? start_y : y_step;
		tx     = is_start ? end_x : tgt_x_q;
		ty     = is_start ? end_y : tgt_y_q;
		at_end = (px == tx) && (py == ty);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			tgt_x_q  <= '0;
			tgt_y_q  <= '0;
			abs_dx_q <= '0;
			abs_dy_q <= '0;
			x_neg_q  <= 1'b0;
			y_neg_q  <= 1'b0;
			err_q    <= '0;
			color_q  <= '0;
			active_q <= 1'b0;
		end else if (take) begin
			if (is_start) begin
				cur_x_q  <= start_x;
				cur_y_q  <= start_y;
				tgt_x_q  <= end_x;
				tgt_y_q  <= end_y;
				abs_dx_q <= dx_abs;
				abs_dy_q <= dy_abs;
				x_neg_q  <= x_neg;
				y_neg_q  <= y_neg;
				err_q    <= err_start;
				color_q  <= line_color;
				active_q <= !at_end;
			end else if (active_q) begin
				cur_x_q  <= x_step;
				cur_y_q  <= y_step;
				err_q    <= err_step;
				active_q <= !at_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// step while idle gives an all-zero item
	always_ff @(posedge clk) begin
		if (take) begin
			flags_s1.valid_res <= emit;
			flags_s1.last      <= emit && at_end;
			pixel_x_s1         <= emit ? px : '0;
			pixel_y_s1         <= emit ? py : '0;
			color_s1           <= is_start ? line_color : (active_q ? color_q : '0);
		end
	end

endmodule

`default_nettype wire

// ----- design/lr_pixel.sv -----
// Second pipeline stage: viewport test and frame-buffer address
// (x + y*width), registered into the output item. Uses lr_pkg.
`default_nettype none

module lr_pixel import lr_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire lr_flags_t                    flags_s1,
	input  wire logic signed [COORD_BITS-1:0] pixel_x_s1,
	input  wire logic signed [COORD_BITS-1:0] pixel_y_s1,
	input  wire logic [COLOR_BITS-1:0]        color_s1,
	input  wire logic [VP_BITS-1:0]           vp_width,
	input  wire logic [VP_BITS-1:0]           vp_height,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output lr_flags_t                         flags_s2,
	output logic                              inside_s2,
	output logic signed [COORD_BITS-1:0]      pixel_x_s2,
	output logic signed [COORD_BITS-1:0]      pixel_y_s2,
	output logic [ADDR_BITS-1:0]              address_s2,
	output logic [COLOR_BITS-1:0]             color_s2
);

	localparam int CW = (COORD_BITS > VP_BITS) ? COORD_BITS : VP_BITS;
	localparam int PW = 2 * VP_BITS;

	logic              valid_s2, take;
	logic [CW-1:0]     x_u, y_u;
	logic [VP_BITS-1:0] x_a, y_a;
	logic [PW-1:0]     prod;
	logic              in_view;
	logic [ADDR_BITS-1:0] addr;

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;
	assign take      = in_valid && in_ready;

	always_comb begin
		x_u     = CW'($unsigned(pixel_x_s1));
		y_u     = CW'($unsigned(pixel_y_s1));
		in_view = flags_s1.valid_res
		          && !pixel_x_s1[COORD_BITS-1] && !pixel_y_s1[COORD_BITS-1]
		          && (x_u < CW'(vp_width)) && (y_u < CW'(vp_height));
		// inside implies both coordinates fit the viewport register width
		x_a     = VP_BITS'(x_u);
		y_a     = VP_BITS'(y_u);
		prod    = PW'(y_a) * PW'(vp_width);
		addr    = ADDR_BITS'(prod + PW'(x_a));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			flags_s2   <= flags_s1;
			inside_s2  <= in_view;
			pixel_x_s2 <= pixel_x_s1;
			pixel_y_s2 <= pixel_y_s1;
			address_s2 <= in_view ? addr : '0;
			color_s2   <= color_s1;
		end
	end

endmodule

`default_nettype wire

// ----- design/line_rasterizer.sv -----
// Top level of the Bresenham line rasteriser: stream ports, viewport
// registers, lr_step and lr_pixel stages. Uses lr_pkg.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | action on tuser, endpoints and colour on tdata
//  m_*     | out | m_tvalid/m_tready  | pixel on tdata, flags on tuser, endpoint on tlast
//  cfg_*   | in  | cfg_wen            | viewport width (0) / height (1)
//
// One item per clock while m_tready is high; every input item gives exactly one result item.
// The Bresenham update is registered into stage 1, the address multiply into stage 2.
// The error-term add/compare loop in lr_step sets the cycle time.
// Reset empties both stages, idles the engine and sets the viewport to 640x480.
// A stall on m_tready backs up through the two stages to s_tready.
`default_nettype none

module line_rasterizer import lr_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// start_x, start_y, end_x, end_y, line_color, zero pad
	input  wire logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_tdata,
	// action
	input  wire logic [0:0]                s_tuser,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// pixel_x, pixel_y, pixel_address, pixel_color, zero pad
	output logic [((2*COORD_BITS+ADDR_BITS+COLOR_BITS+7)/8)*8-1:0] m_tdata,
	// valid_res, inside_res
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast,
	input  wire logic                      cfg_wen,
	input  wire logic [CFG_IDX_BITS-1:0]   cfg_addr,
	input  wire logic [VP_BITS-1:0]        cfg_wdata
);

	localparam int OUT_W = ((2*COORD_BITS+ADDR_BITS+COLOR_BITS+7)/8)*8;
	localparam int C = COORD_BITS;

	logic [VP_BITS-1:0] vp_width_q, vp_height_q;

	logic                 v1, r1;
	lr_flags_t            flags_s1, flags_s2;
	logic signed [C-1:0]  x_s1, y_s1, x_s2, y_s2;
	logic [COLOR_BITS-1:0] color_s1, color_s2;
	logic                 inside_s2;
	logic [ADDR_BITS-1:0] address_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_width_q  <= VP_WIDTH_RESET;
			vp_height_q <= VP_HEIGHT_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_VP_WIDTH:  vp_width_q  <= cfg_wdata;
				REG_VP_HEIGHT: vp_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	lr_step #(.COORD_BITS(C)) u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.action     (s_tuser[0]),
		.start_x    (s_tdata[0*C +: C]),
		.start_y    (s_tdata[1*C +: C]),
		.end_x      (s_tdata[2*C +: C]),
		.end_y      (s_tdata[3*C +: C]),
		.line_color (s_tdata[4*C +: COLOR_BITS]),
		.out_valid  (v1),
		.out_ready  (r1),
		.flags_s1   (flags_s1),
		.pixel_x_s1 (x_s1),
		.pixel_y_s1 (y_s1),
		.color_s1   (color_s1)
	);

	lr_pixel #(.COORD_BITS(C)) u_pixel (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v1),
		.in_ready   (r1),
		.flags_s1   (flags_s1),
		.pixel_x_s1 (x_s1),
		.pixel_y_s1 (y_s1),
		.color_s1   (color_s1),
		.vp_width   (vp_width_q),
		.vp_height  (vp_height_q),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.flags_s2   (flags_s2),
		.inside_s2  (inside_s2),
		.pixel_x_s2 (x_s2),
		.pixel_y_s2 (y_s2),
		.address_s2 (address_s2),
		.color_s2   (color_s2)
	);

	assign m_tdata = OUT_W'({color_s2, address_s2, y_s2, x_s2});
	assign m_tuser = {inside_s2, flags_s2.valid_res};
	assign m_tlast = flags_s2.last;

endmodule

`default_nettype wire

// ----- design/lr_checker.sv -----
// Port-level checks for line_rasterizer, bound to the top level.
// Uses lr_pkg for field widths.
`default_nettype none

module lr_checker import lr_pkg::*; #(
	parameter int COORD_BITS = 16
) (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      s_tvalid,
	input wire logic                      s_tready,
	input wire logic                      m_tvalid,
	input wire logic                      m_tready,
	input wire logic [((2*COORD_BITS+ADDR_BITS+COLOR_BITS+7)/8)*8-1:0] m_tdata,
	input wire logic [1:0]                m_tuser,
	input wire logic                      m_tlast
);

	localparam int ADDR_LO = 2 * COORD_BITS;

	logic       in_acc, out_acc;
	logic [2:0] inflight_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_acc) - 3'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result item changed while stalled");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1] && !m_tlast)
		else $error("idle step item not all zero");

	a_outside_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[ADDR_LO +: ADDR_BITS] == '0)
		else $error("outside pixel carries an address");

	a_one_per_item: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd2 && (!m_tvalid || inflight_q != 3'd0))
		else $error("result count does not match accepted items");

endmodule

bind line_rasterizer lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (.*);

`default_nettype wire
